### design/jdc_pkg.sv
// Package: constants, sequencer states and month-length table for the day-count converter.
`timescale 1ns / 1ps
package jdc_pkg;

  localparam int unsigned DayW  = 32;
  localparam int unsigned YearW = 24;

  localparam logic [DayW-1:0] SWITCH_DAY = 32'd2299161;  // 15 October 1582
  localparam logic [DayW-1:0] GREG_BASE  = 32'd2159411;  // 1 March 1200, Gregorian
  localparam logic [DayW-1:0] GREG_CYCLE = 32'd146097;   // 400 Gregorian years
  localparam logic [DayW-1:0] JUL_CYCLE  = 32'd1461;     // 4 Julian years
  localparam logic [DayW-1:0] CENT_DAYS  = 32'd36524;
  localparam logic [DayW-1:0] QUAD_DAYS  = 32'd1461;
  localparam logic [DayW-1:0] YEAR_DAYS  = 32'd365;
  localparam logic [DayW-1:0] LEAP_DAYS  = 32'd366;

  // Reciprocals for the cycle counts: floor(d / D) == (d * RECIP) >> SHIFT.
  // Gregorian: exact for any 32-bit d. Julian: exact for every count below the switch.
  localparam int unsigned RecipW     = 30;
  localparam int unsigned EraW       = 15;  // widest Gregorian era count
  localparam int unsigned JcycW      = 11;  // widest Julian cycle count
  localparam int unsigned GREG_SHIFT = 47;
  localparam int unsigned JUL_SHIFT  = 32;
  localparam logic [RecipW-1:0] GREG_RECIP = 30'd963315389;
  localparam logic [RecipW-1:0] JUL_RECIP  = 30'd2939745;

  localparam logic [3:0] LAST_MONTH = 4'd11;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_REBASE,
    S_RECIP,
    S_MULBACK,
    S_SETY,
    S_CENT,
    S_QUAD,
    S_GYEAR,
    S_JLEAP,
    S_JYEAR,
    S_MONTH,
    S_FINISH
  } jdc_state_t;

  // Month lengths. Julian months count from January, Gregorian ones from March,
  // so the final (February) entry of the Gregorian year is never subtracted.
  function automatic logic [4:0] month_len(input logic greg, input logic [3:0] idx,
                                           input logic leap);
    logic [4:0] len;
    len = 5'd31;
    if (greg) begin
      case (idx)
        4'd1, 4'd3, 4'd6, 4'd8: len = 5'd30;
        4'd11:                  len = 5'd28;
        default:                len = 5'd31;
      endcase
    end else begin
      case (idx)
        4'd1:                   len = leap ? 5'd29 : 5'd28;
        4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
        default:                len = 5'd31;
      endcase
    end
    return len;
  endfunction

endpackage

### design/jdc_ifs.sv
// Interfaces: request channel carrying a day count and result channel carrying a date.
`timescale 1ns / 1ps
interface jdc_days_if;
  logic        valid;
  logic        ready;
  logic [31:0] day_count;

  modport source (output valid, output day_count, input ready);
  modport sink   (input valid, input day_count, output ready);
endinterface

interface jdc_date_if;
  logic        valid;
  logic        ready;
  logic [4:0]  day_of_month;
  logic [3:0]  month_number;
  logic [23:0] year_magnitude;
  logic        before_christ;

  modport source (output valid, output day_of_month, output month_number,
                  output year_magnitude, output before_christ, input ready);
  modport sink   (input valid, input day_of_month, input month_number,
                  input year_magnitude, input before_christ, output ready);
endinterface

### design/julian_day_to_calendar_date.sv
// Top level: converts a day count since 1 January 4713 BC into a calendar date.
`timescale 1ns / 1ps
// One request is converted at a time by a small sequencer around a single 32-bit
// subtract-and-compare unit and one 32 x 30 constant multiplier. Counts below 2299161
// use the Julian calendar (no year zero, BC leap years 1, 5, 9 BC ...); from
// 15 October 1582 on the Gregorian rules apply. After acceptance a request passes
// through the calendar check (plus a rebase of Gregorian counts to 1 March 1200), the
// 4-year or 400-year cycle count by reciprocal multiplication, a multiply-back and a
// subtraction for the days left, then subtraction of centuries and four-year blocks
// (Gregorian) or of the leap year (Julian), then of years and months, one step at a
// time through the shared unit, and a last step that loads the output register. The
// result sits in an output register, so a new request is taken while a finished date
// still waits for the sink; that request then holds in its last step until the
// register is free.
module julian_day_to_calendar_date
  import jdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  jdc_days_if.sink    days,
  jdc_date_if.source  date
);

  jdc_state_t state, state_next;

  logic [DayW-1:0]  quo, quo_next;     // dividend, then quotient, then days spanned
  logic [DayW-1:0]  rem, rem_next;     // dividend, then days left
  logic [1:0]       cnt, cnt_next;     // century / year step count
  logic [3:0]       mon, mon_next;
  logic             greg, greg_next;
  logic             leap, leap_next;
  logic signed [24:0] year, year_next; // astronomical year

  logic             out_valid, out_valid_next;
  logic [4:0]       day_r, day_next;
  logic [3:0]       month_r, month_next;
  logic [YearW-1:0] mag_r, mag_next;
  logic             bc_r, bc_next;

  // Shared unit operands
  logic [DayW-1:0] sub_a, sub_b, sub_diff;
  logic            sub_ok;

  // Constant multiplier operands
  logic [DayW-1:0]        mul_a;
  logic [RecipW-1:0]      mul_b;
  logic [DayW+RecipW-1:0] mul_prod;

  jdc_sub u_sub (
    .a    (sub_a),
    .b    (sub_b),
    .diff (sub_diff),
    .ok   (sub_ok)
  );

  assign mul_prod = {{RecipW{1'b0}}, mul_a} * {{DayW{1'b0}}, mul_b};

  // Year start after the division
  logic [24:0]        era_ext;
  logic signed [24:0] greg_start, jul_start;
  // Final formatting
  logic               feb_adj;
  logic signed [24:0] astro;
  logic [24:0]        mag_full;
  logic               load_out;

  assign era_ext    = {10'd0, quo[14:0]};
  assign greg_start = $signed((era_ext << 8) + (era_ext << 7) + (era_ext << 4) + 25'd1200);
  assign jul_start  = $signed({12'd0, quo[10:0], 2'b00}) - 25'sd4712;

  // Gregorian months run March..February; January and February belong to the next year.
  assign feb_adj  = greg && (mon >= 4'd10);
  assign astro    = year + $signed({24'd0, feb_adj});
  assign mag_full = (astro <= 25'sd0) ? $unsigned(25'sd1 - astro) : $unsigned(astro);
  assign load_out = !out_valid || date.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    quo     <= quo_next;
    rem     <= rem_next;
    cnt     <= cnt_next;
    mon     <= mon_next;
    greg    <= greg_next;
    leap    <= leap_next;
    year    <= year_next;
    day_r   <= day_next;
    month_r <= month_next;
    mag_r   <= mag_next;
    bc_r    <= bc_next;
  end

  always_comb begin
    state_next     = state;
    quo_next       = quo;
    rem_next       = rem;
    cnt_next       = cnt;
    mon_next       = mon;
    greg_next      = greg;
    leap_next      = leap;
    year_next      = year;
    day_next       = day_r;
    month_next     = month_r;
    mag_next       = mag_r;
    bc_next        = bc_r;
    out_valid_next = out_valid && !date.ready;
    sub_a          = rem;
    sub_b          = '0;
    mul_a          = quo;
    mul_b          = '0;

    case (state)
      S_IDLE: begin
        if (days.valid) begin
          quo_next   = days.day_count;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        // pick the calendar
        sub_a       = quo;
        sub_b       = SWITCH_DAY;
        greg_next   = sub_ok;
        rem_next    = '0;
        state_next  = sub_ok ? S_REBASE : S_RECIP;
      end
      S_REBASE: begin
        // count from 1 March 1200
        sub_a      = quo;
        sub_b      = GREG_BASE;
        quo_next   = sub_diff;
        state_next = S_RECIP;
      end
      S_RECIP: begin
        // cycle count by reciprocal multiplication; keep the dividend for the remainder
        mul_b      = greg ? GREG_RECIP : JUL_RECIP;
        rem_next   = quo;
        quo_next   = greg ? {{(DayW-EraW){1'b0}}, mul_prod[GREG_SHIFT +: EraW]}
                          : {{(DayW-JcycW){1'b0}}, mul_prod[JUL_SHIFT +: JcycW]};
        state_next = S_MULBACK;
      end
      S_MULBACK: begin
        // set the cycle's first year, then multiply back for the days it spans
        mul_b      = greg ? GREG_CYCLE[RecipW-1:0] : JUL_CYCLE[RecipW-1:0];
        year_next  = greg ? greg_start : jul_start;
        quo_next   = mul_prod[DayW-1:0];
        state_next = S_SETY;
      end
      S_SETY: begin
        // days left inside the cycle
        sub_b      = quo;
        rem_next   = sub_diff;
        cnt_next   = '0;
        state_next = greg ? S_CENT : S_JLEAP;
      end
      S_CENT: begin
        // at most three full centuries; the fourth keeps the extra leap day
        sub_b = CENT_DAYS;
        if (sub_ok && cnt != 2'd3) begin
          rem_next  = sub_diff;
          year_next = year + 25'sd100;
          cnt_next  = cnt + 2'd1;
        end else begin
          cnt_next   = '0;
          state_next = S_QUAD;
        end
      end
      S_QUAD: begin
        sub_b = QUAD_DAYS;
        if (sub_ok) begin
          rem_next  = sub_diff;
          year_next = year + 25'sd4;
        end else begin
          state_next = S_GYEAR;
        end
      end
      S_GYEAR: begin
        sub_b = YEAR_DAYS;
        if (sub_ok && cnt != 2'd3) begin
          rem_next  = sub_diff;
          year_next = year + 25'sd1;
          cnt_next  = cnt + 2'd1;
        end else begin
          mon_next   = '0;
          state_next = S_MONTH;
        end
      end
      S_JLEAP: begin
        // first year of each Julian cycle is the leap year
        sub_b = LEAP_DAYS;
        if (sub_ok) begin
          rem_next   = sub_diff;
          year_next  = year + 25'sd1;
          leap_next  = 1'b0;
          state_next = S_JYEAR;
        end else begin
          leap_next  = 1'b1;
          mon_next   = '0;
          state_next = S_MONTH;
        end
      end
      S_JYEAR: begin
        sub_b = YEAR_DAYS;
        if (sub_ok) begin
          rem_next  = sub_diff;
          year_next = year + 25'sd1;
        end else begin
          mon_next   = '0;
          state_next = S_MONTH;
        end
      end
      S_MONTH: begin
        sub_b = {27'd0, month_len(greg, mon, leap)};
        if (sub_ok && mon != LAST_MONTH) begin
          rem_next = sub_diff;
          mon_next = mon + 4'd1;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        // hold until the output register is free
        if (load_out) begin
          day_next       = rem[4:0] + 5'd1;
          month_next     = greg ? ((mon < 4'd10) ? mon + 4'd3 : mon - 4'd9) : mon + 4'd1;
          mag_next       = mag_full[YearW-1:0];
          bc_next        = (astro <= 25'sd0);
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign days.ready          = (state == S_IDLE);
  assign date.valid          = out_valid;
  assign date.day_of_month   = day_r;
  assign date.month_number   = month_r;
  assign date.year_magnitude = mag_r;
  assign date.before_christ  = bc_r;

  // An accepted request always starts with the calendar check.
  a_accept_check: assert property (@(posedge clk) disable iff (rst)
    days.valid && days.ready |=> state == S_CHECK)
    else $error("accepted request did not enter calendar check");

  // The reciprocal quotient never overshoots, so the days left are never negative.
  a_rem_sign: assert property (@(posedge clk) disable iff (rst)
    state == S_SETY |-> sub_ok)
    else $error("cycle count too large");

  // Month walk never passes the last month.
  a_month_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_MONTH |-> mon <= LAST_MONTH)
    else $error("month index out of range");

  // A delivered date is well formed.
  a_date_sane: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> day_r != 5'd0 && month_r != 4'd0 && month_r <= 4'd12 && mag_r != 24'd0)
    else $error("malformed date in output register");

endmodule

### design/jdc_sub.sv
// Shared subtract-and-compare unit used by the compare and subtract steps of the converter.
`timescale 1ns / 1ps
module jdc_sub
  import jdc_pkg::*;
(
  input  logic [DayW-1:0] a,
  input  logic [DayW-1:0] b,
  output logic [DayW-1:0] diff,
  output logic            ok
);
  logic borrow;

  assign {borrow, diff} = {1'b0, a} - {1'b0, b};
  assign ok = ~borrow;   // a >= b
endmodule

### test/tb_top.sv
// Testbench: drives day counts into the day-count converter and checks every returned date.
`timescale 1ns / 1ps
module tb_top;
  import jdc_pkg::*;

  // Run limits. The slowest correct run is roughly 1350 requests plus receiver stalls
  // and three long hold-offs.
  localparam int TIMEOUT_NS  = 20_000_000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_LIMIT = 20_000;
  localparam int QUIET_TAIL  = 100;
  localparam int REPORT_MAX  = 10;

  // Landmark day counts used to aim the stimulus.
  localparam logic [31:0] AD_ONE_DAY = 32'd1721424;  // 1 January AD 1
  localparam logic [31:0] Y2K_DAY    = 32'd2451545;  // 1 January 2000

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [23:0] year;
    logic        bc;
  } cal_date_t;

  typedef struct packed {
    logic [31:0] count;
    cal_date_t   date;
  } pending_date_t;

  logic clk = 1'b0;
  logic rst;

  jdc_days_if days_ch ();
  jdc_date_if date_ch ();

  julian_day_to_calendar_date u_top (
    .clk  (clk),
    .rst  (rst),
    .days (days_ch),
    .date (date_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Dates still owed by the block, oldest first.
  pending_date_t pending_dates[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  logic hold_on = 1'b0;
  event start_hold;

  int sent_count     = 0;
  int julian_count   = 0;
  int checked_count  = 0;
  int mismatch_count = 0;

  // Calendar arithmetic. Below the switch day, walk the 4-year Julian cycle whose
  // first year is the leap year; from the switch day on, count 400-year Gregorian
  // eras from 1 March 1200 so that February falls at the end of each year.
  function automatic cal_date_t predict_date(input logic [31:0] cnt);
    longint unsigned r, cycles, rem, k, doy, d, era, doe, yoe, mp, day, mon, len;
    longint astro;
    logic leap, found;
    cal_date_t res;
    r = cnt;
    if (cnt < SWITCH_DAY) begin
      cycles = r / JUL_CYCLE;
      rem    = r % JUL_CYCLE;
      if (rem < LEAP_DAYS) begin
        k    = 0;
        doy  = rem;
        leap = 1'b1;
      end else begin
        k    = 1 + (rem - LEAP_DAYS) / YEAR_DAYS;
        doy  = (rem - LEAP_DAYS) % YEAR_DAYS;
        leap = 1'b0;
      end
      astro = longint'(4 * cycles + k) - 4712;
      // Strip whole months from January on; December takes what is left.
      found = 1'b0;
      mon   = 12;
      for (int mi = 0; mi < 11; mi++) begin
        case (mi)
          1:             len = leap ? 29 : 28;
          3, 5, 8, 10:   len = 30;
          default:       len = 31;
        endcase
        if (!found) begin
          if (doy < len) begin
            found = 1'b1;
            mon   = mi + 1;
          end else begin
            doy -= len;
          end
        end
      end
      day = doy + 1;
    end else begin
      d     = r - GREG_BASE;
      era   = d / GREG_CYCLE;
      doe   = d % GREG_CYCLE;
      yoe   = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
      doy   = doe - (365 * yoe + yoe / 4 - yoe / 100);
      mp    = (5 * doy + 2) / 153;
      day   = doy - (153 * mp + 2) / 5 + 1;
      mon   = (mp < 10) ? mp + 3 : mp - 9;
      astro = longint'(1200 + 400 * era + yoe + ((mon <= 2) ? 1 : 0));
    end
    // No year zero: astronomical year 0 is 1 BC.
    if (astro <= 0) begin
      res.year = 24'(1 - astro);
      res.bc   = 1'b1;
    end else begin
      res.year = 24'(astro);
      res.bc   = 1'b0;
    end
    res.day   = day[4:0];
    res.month = mon[3:0];
    return res;
  endfunction

  // Offer one request and hold it until the block takes it. Valid is only lowered
  // during an idle gap, so back-to-back requests keep it high without a glitch.
  task automatic send_day(input logic [31:0] cnt);
    pending_date_t entry;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      days_ch.valid <= 1'b0;
      @(posedge clk);
    end
    days_ch.valid     <= 1'b1;
    days_ch.day_count <= cnt;
    do @(posedge clk); while (!days_ch.ready);
    entry.count = cnt;
    entry.date  = predict_date(cnt);
    pending_dates.push_back(entry);
    sent_count++;
    if (cnt < SWITCH_DAY) julian_count++;
  endtask

  // Long receiver hold-off, counted here so the test tasks need not track it.
  initial begin
    forever begin
      @(start_hold);
      hold_on <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_on <= 1'b0;
    end
  end

  // Result side: check each accepted date against the oldest owed one, then decide
  // whether to stall for the next cycle.
  always @(posedge clk) begin : check_dates
    pending_date_t want;
    cal_date_t got;
    if (!rst && date_ch.valid && date_ch.ready) begin
      got = '{date_ch.day_of_month, date_ch.month_number, date_ch.year_magnitude,
              date_ch.before_christ};
      if (pending_dates.size() == 0) begin
        if (mismatch_count < REPORT_MAX)
          $display("[%0t] unexpected date %0d/%0d/%0d bc=%0b", $realtime, got.day,
                   got.month, got.year, got.bc);
        mismatch_count++;
      end else begin
        want = pending_dates.pop_front();
        checked_count++;
        if (got.day !== want.date.day || got.month !== want.date.month ||
            got.year !== want.date.year || got.bc !== want.date.bc) begin
          if (mismatch_count < REPORT_MAX)
            $display("[%0t] count %0d: expected %0d/%0d/%0d bc=%0b, got %0d/%0d/%0d bc=%0b",
                     $realtime, want.count, want.date.day, want.date.month,
                     want.date.year, want.date.bc, got.day, got.month, got.year, got.bc);
          mismatch_count++;
        end
      end
    end
    if (rst || hold_on)
      date_ch.ready <= 1'b0;
    else
      date_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Corner counts: epoch, first leap day, year ends, the BC/AD turn, both sides of
  // the calendar switch, Gregorian century rules, the top of the range and some
  // alternating bit patterns.
  task automatic test_directed;
    logic [31:0] corner_days [24] = '{
      32'd0, 32'd1, 32'd59, 32'd60, 32'd365, 32'd366,
      32'd1721423, 32'd1721424, 32'd2299159, 32'd2299160, 32'd2299161, 32'd2299162,
      32'd2415079, 32'd2415080, 32'd2451604, 32'd2451605, 32'd2451910, 32'hFFFF_FFFF,
      32'hFFFF_FFFE, 32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
      32'hFFFF_0000};
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    foreach (corner_days[i]) send_day(corner_days[i]);
  endtask

  // Julian range only, with a sluggish sender.
  task automatic test_julian_span(input int n);
    send_idle_pct  = 78;
    recv_stall_pct = 0;
    repeat (n) send_day($urandom_range(SWITCH_DAY - 1, 0));
  endtask

  // Gregorian range, mostly recent centuries, against a stalling receiver.
  task automatic test_gregorian_span(input int n);
    send_idle_pct  = 0;
    recv_stall_pct = 78;
    repeat (n) begin
      if ($urandom_range(3) != 0)
        send_day($urandom_range(32'd3000000, SWITCH_DAY));
      else
        send_day($urandom_range(32'hFFFF_FFFF, SWITCH_DAY));
    end
  endtask

  // Whole 32-bit range, so every input bit toggles, with light idling on both sides.
  task automatic test_full_range(input int n);
    send_idle_pct  = 14;
    recv_stall_pct = 14;
    repeat (n) send_day($urandom());
  endtask

  // Dense requests around the BC/AD turn, the calendar switch and a Gregorian
  // leap century, with no idling at all.
  task automatic test_calendar_switch(input int n);
    logic [31:0] centre;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (n) begin
      case ($urandom_range(2))
        0:       centre = AD_ONE_DAY;
        1:       centre = SWITCH_DAY;
        default: centre = Y2K_DAY;
      endcase
      send_day(centre + $urandom_range(1600) - 32'd800);
    end
  endtask

  // Hold the result side off for a long stretch while requests keep coming, so
  // the block fills up and stalls its input; repeat a few rounds.
  task automatic test_backpressure(input int rounds, input int per_round);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (rounds) begin
      -> start_hold;
      repeat (per_round) send_day($urandom());
    end
  endtask

  initial begin
    int waited;
    rst               <= 1'b1;
    days_ch.valid     <= 1'b0;
    days_ch.day_count <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_julian_span(300);
    test_gregorian_span(300);
    test_full_range(300);
    test_calendar_switch(150);
    test_backpressure(3, 90);

    // Drain: drop valid, let every owed date arrive, then allow a quiet tail.
    days_ch.valid  <= 1'b0;
    recv_stall_pct = 0;
    waited = 0;
    while (pending_dates.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (QUIET_TAIL) @(posedge clk);
    if (pending_dates.size() != 0)
      $display("%0d dates never arrived", pending_dates.size());

    $display("Converted %0d day counts (%0d Julian, %0d Gregorian), %0d dates checked,",
             sent_count, julian_count, sent_count - julian_count, checked_count);
    $display("over corners, range sweeps, the calendar switch and long back-pressure; %0d errors",
             mismatch_count + pending_dates.size());
    if (mismatch_count == 0 && pending_dates.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Timed out with %0d dates outstanding", pending_dates.size());
    $display("Verification failed");
    $finish;
  end

endmodule

### sim.f
design/jdc_pkg.sv
design/jdc_ifs.sv
design/jdc_sub.sv
design/julian_day_to_calendar_date.sv
test/tb_top.sv
